// ===== rtl/ocr_pkg.sv =====
// Shared constants, types and helper functions of the outline coverage rasterizer.
`default_nettype none
package ocr_pkg;

  localparam int GRID_WIDTH_DEF  = 32;
  localparam int GRID_HEIGHT_DEF = 32;
  localparam int COORD_W         = 12;
  localparam int CFG_W           = 6;
  localparam int CFG_RESET       = 32;
  localparam int ROW_W           = 5;
  localparam int PIX_W           = 8;
  localparam int OP_W            = 14;
  localparam int MUL_W           = 2 * OP_W;
  localparam int NUM_W           = 26;
  localparam int DEN_W           = 13;
  localparam int QUO_W           = 12;
  localparam int ACC_W           = 16;
  localparam int CELL_W          = 16;
  localparam int UNIT            = 127;
  localparam int AREA_MAX        = 254;
  localparam int COVER_MAX       = 127;
  localparam int PIX_MAX         = 255;

  typedef enum logic [4:0] {
    S_IDLE, S_INIT, S_STEP, S_CMPA, S_CMPB, S_TAKE,
    S_COIN1, S_COIN2, S_COIN3,
    S_I1, S_I2, S_I3, S_IW,
    S_PC, S_PA, S_PR, S_PW, S_PN,
    S_RBASE, S_RRD, S_RMUL, S_RSUM, S_ROUT
  } state_t;

  typedef enum logic {
    FUNC_LINE    = 1'b0,
    FUNC_RESOLVE = 1'b1
  } func_t;

  // Quotient by 127 through a reciprocal multiply and one correction step.
  function automatic logic [8:0] div127(input logic [15:0] v);
    logic [26:0] m;
    logic [8:0]  q;
    logic [15:0] r;
    m = 27'(v) * 27'(1032);
    q = 9'(m >> 17);
    r = v - 16'(q) * 16'(UNIT);
    if (r >= 16'(UNIT)) begin
      q = q + 9'd1;
    end
    return q;
  endfunction

  function automatic logic signed [OP_W-1:0] to_op(input logic [COORD_W-1:0] v);
    return $signed({{(OP_W-COORD_W){1'b0}}, v});
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ocr_div.sv =====
// Restoring divider, one quotient bit per cycle, for crossing interpolation.
`default_nettype none
module ocr_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [ocr_pkg::NUM_W-1:0]   num,
  input  wire logic [ocr_pkg::DEN_W-1:0]   den,
  output logic                             done,
  output logic [ocr_pkg::QUO_W-1:0]        quo
);

  localparam int CW = $clog2(ocr_pkg::QUO_W);

  logic                      run_r, run_nxt;
  logic                      done_r, done_nxt;
  logic [CW-1:0]             cnt_r, cnt_nxt;
  logic [ocr_pkg::NUM_W-1:0] rem_r, rem_nxt;
  logic [ocr_pkg::DEN_W-1:0] den_r, den_nxt;
  logic [ocr_pkg::QUO_W-1:0] quo_r, quo_nxt;
  logic [ocr_pkg::NUM_W-1:0] sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    sh       = ocr_pkg::NUM_W'(den_r) << cnt_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = CW'(ocr_pkg::QUO_W - 1);
      rem_nxt = num;
      den_nxt = den;
      quo_nxt = '0;
    end else if (run_r) begin
      if (rem_r >= sh) begin
        rem_nxt = rem_r - sh;
        quo_nxt = {quo_r[ocr_pkg::QUO_W-2:0], 1'b1};
      end else begin
        quo_nxt = {quo_r[ocr_pkg::QUO_W-2:0], 1'b0};
      end
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - CW'(1);
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
`default_nettype wire

// ===== rtl/ocr_store.sv =====
// Cell memory holding cover and area, with a clearing sweep after reset.
`default_nettype none
module ocr_store #(
  parameter int DEPTH = ocr_pkg::GRID_WIDTH_DEF * ocr_pkg::GRID_HEIGHT_DEF,
  parameter int AW    = $clog2(ocr_pkg::GRID_WIDTH_DEF * ocr_pkg::GRID_HEIGHT_DEF)
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         rd_en,
  input  wire logic [AW-1:0]                rd_addr,
  output logic [ocr_pkg::CELL_W-1:0]        rd_data,
  input  wire logic                         wr_en,
  input  wire logic [AW-1:0]                wr_addr,
  input  wire logic [ocr_pkg::CELL_W-1:0]   wr_data,
  output logic                              busy
);

  logic [ocr_pkg::CELL_W-1:0] mem [DEPTH];
  logic [ocr_pkg::CELL_W-1:0] rd_data_r;
  logic                       busy_r, busy_nxt;
  logic [AW-1:0]              clr_r, clr_nxt;
  logic                       we;
  logic [AW-1:0]              wa;
  logic [ocr_pkg::CELL_W-1:0] wd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      clr_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      clr_r  <= clr_nxt;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    clr_nxt  = clr_r;
    if (busy_r) begin
      if (clr_r == AW'(DEPTH - 1)) begin
        busy_nxt = 1'b0;
      end else begin
        clr_nxt = clr_r + AW'(1);
      end
    end
    we = busy_r ? 1'b1 : wr_en;
    wa = busy_r ? clr_r : wr_addr;
    wd = busy_r ? '0 : wr_data;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = busy_r;

endmodule
`default_nettype wire

// ===== rtl/outline_coverage_rasterizer_unit.sv =====
// Top level: sequencer with shared multiplier driving the divider and cell store.
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  in      | in_valid, in_stall, in_func, in_begin/end_x/y,  | to block
//          | in_row_index                                    |
//  out     | out_valid, out_stall, out_pixel, out_column,    | from block
//          | out_last                                        |
//  cfg     | cfg_we, cfg_wdata (active_width)                | to block
//
// One shared 14x14 multiplier and one 12-step divider serve every step.
// An add-line item takes a setup step, then per edge crossing that makes a piece
// an axis choice, a coincidence check, two divider interpolations and a cell
// read and write (none off the grid; a repeated crossing stops at the check),
// then the closing piece; resolve sends each column, waiting while out stalls.
// After reset the store sweeps GRID_WIDTH*GRID_HEIGHT cells to zero
// before the first transfer is taken. in_stall is high while an item is at work.
`default_nettype none
module outline_coverage_rasterizer_unit #(
  parameter int GRID_WIDTH  = ocr_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = ocr_pkg::GRID_HEIGHT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [ocr_pkg::CFG_W-1:0]     cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_func,
  input  wire logic [ocr_pkg::COORD_W-1:0]   in_begin_x,
  input  wire logic [ocr_pkg::COORD_W-1:0]   in_begin_y,
  input  wire logic [ocr_pkg::COORD_W-1:0]   in_end_x,
  input  wire logic [ocr_pkg::COORD_W-1:0]   in_end_y,
  input  wire logic [ocr_pkg::ROW_W-1:0]     in_row_index,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [ocr_pkg::PIX_W-1:0]          out_pixel,
  output logic [4:0]                         out_column,
  output logic                               out_last
);

  localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CW    = ocr_pkg::COORD_W;
  localparam int OW    = ocr_pkg::OP_W;
  localparam int MW    = ocr_pkg::MUL_W;
  localparam int AC    = ocr_pkg::ACC_W;

  ocr_pkg::state_t state_r, state_nxt;

  logic [ocr_pkg::CFG_W-1:0] cfg_r;
  logic [ocr_pkg::CFG_W-1:0] w;

  logic [CW-1:0] bx_r, by_r, ex_r, ey_r, bx_nxt, by_nxt, ex_nxt, ey_nxt;
  logic [ocr_pkg::ROW_W-1:0] row_r, row_nxt;
  logic signed [CW:0]   dx_r, dy_r, dx_nxt, dy_nxt;
  logic signed [OW-1:0] nx_r, ny_r, nx_nxt, ny_nxt;
  logic [CW-1:0] pn_r, pd_r, tn_r, td_r, qx_r, qy_r, ix_r, iy_r;
  logic [CW-1:0] pn_nxt, pd_nxt, tn_nxt, td_nxt, qx_nxt, qy_nxt, ix_nxt, iy_nxt;
  logic takex_r, axis_r, final_r, row_ok_r;
  logic takex_nxt, axis_nxt, final_nxt, row_ok_nxt;
  logic signed [MW-1:0] pa_r, pb_r, pa_nxt, pb_nxt;
  logic [5:0] cx_r, cy_r, cx_nxt, cy_nxt;
  logic signed [AC-1:0] acc_r, v_r, acc_nxt, v_nxt;
  logic [ocr_pkg::CFG_W-1:0] col_r, col_nxt;
  logic out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic [ocr_pkg::PIX_W-1:0] out_pixel_r, out_pixel_nxt;
  logic [4:0] out_column_r, out_column_nxt;

  logic signed [OW-1:0] mul_a, mul_b;
  logic signed [MW-1:0] mul_p;

  logic okx, oky;
  logic signed [OW-1:0] xn, yn, xd, yd;
  logic [CW-1:0] pex, pey;

  logic                       div_start;
  logic [ocr_pkg::NUM_W-1:0]  div_num;
  logic [ocr_pkg::DEN_W-1:0]  div_den;
  logic                       div_done;
  logic [ocr_pkg::QUO_W-1:0]  div_quo;

  logic                         st_rd_en, st_wr_en, st_busy;
  logic [AW-1:0]                st_rd_addr, st_wr_addr;
  logic [ocr_pkg::CELL_W-1:0]   st_rd_data, st_wr_data;

  logic signed [OW-1:0] cx127, fbx, fex, bsel;
  logic signed [OW-1:0] dsel;
  logic signed [MW-1:0] psum;
  logic signed [15:0]   csum, asum;
  logic signed [7:0]    cv;
  logic [7:0]           ar, cabs;
  logic [8:0]           q9;
  logic [AC-1:0]        vabs;
  logic [CW-1:0]        minx, miny;

  ocr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  ocr_store #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (st_rd_en),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_data (st_wr_data),
    .busy    (st_busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ocr_pkg::S_IDLE;
      cfg_r       <= ocr_pkg::CFG_W'(ocr_pkg::CFG_RESET);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
    end
    bx_r <= bx_nxt;  by_r <= by_nxt;  ex_r <= ex_nxt;  ey_r <= ey_nxt;
    row_r <= row_nxt;
    dx_r <= dx_nxt;  dy_r <= dy_nxt;  nx_r <= nx_nxt;  ny_r <= ny_nxt;
    pn_r <= pn_nxt;  pd_r <= pd_nxt;  tn_r <= tn_nxt;  td_r <= td_nxt;
    qx_r <= qx_nxt;  qy_r <= qy_nxt;  ix_r <= ix_nxt;  iy_r <= iy_nxt;
    takex_r <= takex_nxt;  axis_r <= axis_nxt;  final_r <= final_nxt;
    row_ok_r <= row_ok_nxt;
    pa_r <= pa_nxt;  pb_r <= pb_nxt;
    cx_r <= cx_nxt;  cy_r <= cy_nxt;
    acc_r <= acc_nxt;  v_r <= v_nxt;  col_r <= col_nxt;
    out_last_r <= out_last_nxt;  out_pixel_r <= out_pixel_nxt;
    out_column_r <= out_column_nxt;
  end

  always_comb begin
    if (cfg_r == '0) begin
      w = ocr_pkg::CFG_W'(1);
    end else if (int'(cfg_r) > GRID_WIDTH) begin
      w = ocr_pkg::CFG_W'(GRID_WIDTH);
    end else begin
      w = cfg_r;
    end
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    okx = (dx_r > 0 && nx_r <= ocr_pkg::to_op(ex_r)) ||
          (dx_r < 0 && nx_r >= ocr_pkg::to_op(ex_r));
    oky = (dy_r > 0 && ny_r <= ocr_pkg::to_op(ey_r)) ||
          (dy_r < 0 && ny_r >= ocr_pkg::to_op(ey_r));
    xn  = (dx_r > 0) ? nx_r - ocr_pkg::to_op(bx_r) : ocr_pkg::to_op(bx_r) - nx_r;
    yn  = (dy_r > 0) ? ny_r - ocr_pkg::to_op(by_r) : ocr_pkg::to_op(by_r) - ny_r;
    xd  = (dx_r < 0) ? -OW'(dx_r) : OW'(dx_r);
    yd  = (dy_r < 0) ? -OW'(dy_r) : OW'(dy_r);
    pex = final_r ? ex_r : ix_r;
    pey = final_r ? ey_r : iy_r;
    minx = (qx_r < pex) ? qx_r : pex;
    miny = (qy_r < pey) ? qy_r : pey;
    bsel = axis_r ? ocr_pkg::to_op(by_r) : ocr_pkg::to_op(bx_r);
    dsel = axis_r ? OW'(dy_r) : OW'(dx_r);
    psum = pa_r + pb_r;
    cx127 = OW'(cx_r) * OW'(ocr_pkg::UNIT);
    fbx  = ocr_pkg::to_op(qx_r) - cx127;
    fex  = ocr_pkg::to_op(pex) - cx127;
    csum = 16'($signed(st_rd_data[15:8])) + 16'(ocr_pkg::to_op(pey) - ocr_pkg::to_op(qy_r));
    asum = $signed({8'b0, st_rd_data[7:0]}) + 16'(ocr_pkg::AREA_MAX) - 16'(fex) - 16'(fbx);
    cv   = row_ok_r ? $signed(st_rd_data[15:8]) : 8'sd0;
    ar   = row_ok_r ? st_rd_data[7:0] : 8'd0;
    cabs = cv[7] ? 8'(-cv) : 8'(cv);
    q9   = ocr_pkg::div127(16'(pb_r >>> 1));
    vabs = v_r[AC-1] ? AC'(-v_r) : AC'(v_r);
  end

  always_comb begin
    state_nxt = state_r;
    bx_nxt = bx_r;  by_nxt = by_r;  ex_nxt = ex_r;  ey_nxt = ey_r;
    row_nxt = row_r;
    dx_nxt = dx_r;  dy_nxt = dy_r;  nx_nxt = nx_r;  ny_nxt = ny_r;
    pn_nxt = pn_r;  pd_nxt = pd_r;  tn_nxt = tn_r;  td_nxt = td_r;
    qx_nxt = qx_r;  qy_nxt = qy_r;  ix_nxt = ix_r;  iy_nxt = iy_r;
    takex_nxt = takex_r;  axis_nxt = axis_r;  final_nxt = final_r;
    row_ok_nxt = row_ok_r;
    pa_nxt = pa_r;  pb_nxt = pb_r;  cx_nxt = cx_r;  cy_nxt = cy_r;
    acc_nxt = acc_r;  v_nxt = v_r;  col_nxt = col_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_last_nxt = out_last_r;  out_pixel_nxt = out_pixel_r;
    out_column_nxt = out_column_r;
    mul_a = '0;
    mul_b = '0;
    div_start = 1'b0;
    div_num = {psum[ocr_pkg::NUM_W-2:0], 1'b0} + ocr_pkg::NUM_W'(td_r);
    div_den = {1'b0, td_r} << 1;
    st_rd_en = 1'b0;
    st_rd_addr = pa_r[AW-1:0] + AW'(cx_r);
    st_wr_en = 1'b0;
    st_wr_addr = pa_r[AW-1:0] + AW'(cx_r);
    st_wr_data = '0;
    in_stall = st_busy || (state_r != ocr_pkg::S_IDLE);

    unique case (state_r)
      ocr_pkg::S_IDLE: begin
        if (in_valid && !in_stall) begin
          bx_nxt = in_begin_x;  by_nxt = in_begin_y;
          ex_nxt = in_end_x;    ey_nxt = in_end_y;
          row_nxt = in_row_index;
          state_nxt = (in_func == ocr_pkg::FUNC_RESOLVE) ? ocr_pkg::S_RBASE
                                                          : ocr_pkg::S_INIT;
        end
      end
      ocr_pkg::S_INIT: begin
        dx_nxt = $signed({1'b0, ex_r}) - $signed({1'b0, bx_r});
        dy_nxt = $signed({1'b0, ey_r}) - $signed({1'b0, by_r});
        if (ex_r > bx_r) begin
          nx_nxt = OW'(ocr_pkg::div127(16'(bx_r) + 16'(ocr_pkg::UNIT - 1))) * OW'(ocr_pkg::UNIT);
        end else begin
          nx_nxt = OW'(ocr_pkg::div127(16'(bx_r))) * OW'(ocr_pkg::UNIT);
        end
        if (ey_r > by_r) begin
          ny_nxt = OW'(ocr_pkg::div127(16'(by_r) + 16'(ocr_pkg::UNIT - 1))) * OW'(ocr_pkg::UNIT);
        end else begin
          ny_nxt = OW'(ocr_pkg::div127(16'(by_r))) * OW'(ocr_pkg::UNIT);
        end
        pn_nxt = '0;
        pd_nxt = CW'(1);
        qx_nxt = bx_r;
        qy_nxt = by_r;
        final_nxt = 1'b0;
        state_nxt = ocr_pkg::S_STEP;
      end
      ocr_pkg::S_STEP: begin
        mul_a = xn;
        mul_b = yd;
        if (!okx && !oky) begin
          final_nxt = 1'b1;
          state_nxt = ocr_pkg::S_PC;
        end else if (okx && oky) begin
          pa_nxt = mul_p;
          state_nxt = ocr_pkg::S_CMPA;
        end else begin
          takex_nxt = okx;
          state_nxt = ocr_pkg::S_TAKE;
        end
      end
      ocr_pkg::S_CMPA: begin
        mul_a = yn;
        mul_b = xd;
        pb_nxt = mul_p;
        state_nxt = ocr_pkg::S_CMPB;
      end
      ocr_pkg::S_CMPB: begin
        takex_nxt = pa_r < pb_r;
        state_nxt = ocr_pkg::S_TAKE;
      end
      ocr_pkg::S_TAKE: begin
        if (takex_r) begin
          tn_nxt = CW'(xn);
          td_nxt = CW'(xd);
          nx_nxt = (dx_r > 0) ? nx_r + OW'(ocr_pkg::UNIT) : nx_r - OW'(ocr_pkg::UNIT);
        end else begin
          tn_nxt = CW'(yn);
          td_nxt = CW'(yd);
          ny_nxt = (dy_r > 0) ? ny_r + OW'(ocr_pkg::UNIT) : ny_r - OW'(ocr_pkg::UNIT);
        end
        state_nxt = ocr_pkg::S_COIN1;
      end
      ocr_pkg::S_COIN1: begin
        mul_a = ocr_pkg::to_op(tn_r);
        mul_b = ocr_pkg::to_op(pd_r);
        pa_nxt = mul_p;
        state_nxt = ocr_pkg::S_COIN2;
      end
      ocr_pkg::S_COIN2: begin
        mul_a = ocr_pkg::to_op(pn_r);
        mul_b = ocr_pkg::to_op(td_r);
        pb_nxt = mul_p;
        state_nxt = ocr_pkg::S_COIN3;
      end
      ocr_pkg::S_COIN3: begin
        axis_nxt = 1'b0;
        state_nxt = (pa_r == pb_r) ? ocr_pkg::S_STEP : ocr_pkg::S_I1;
      end
      ocr_pkg::S_I1: begin
        mul_a = bsel;
        mul_b = ocr_pkg::to_op(td_r);
        pa_nxt = mul_p;
        state_nxt = ocr_pkg::S_I2;
      end
      ocr_pkg::S_I2: begin
        mul_a = ocr_pkg::to_op(tn_r);
        mul_b = dsel;
        pb_nxt = mul_p;
        state_nxt = ocr_pkg::S_I3;
      end
      ocr_pkg::S_I3: begin
        if (psum < 0) begin
          div_num = ocr_pkg::NUM_W'(td_r);
        end
        div_start = 1'b1;
        state_nxt = ocr_pkg::S_IW;
      end
      ocr_pkg::S_IW: begin
        if (div_done) begin
          if (axis_r) begin
            iy_nxt = div_quo;
            state_nxt = ocr_pkg::S_PC;
          end else begin
            ix_nxt = div_quo;
            axis_nxt = 1'b1;
            state_nxt = ocr_pkg::S_I1;
          end
        end
      end
      ocr_pkg::S_PC: begin
        cx_nxt = 6'(ocr_pkg::div127(16'(minx)));
        cy_nxt = 6'(ocr_pkg::div127(16'(miny)));
        state_nxt = ocr_pkg::S_PA;
      end
      ocr_pkg::S_PA: begin
        mul_a = OW'(cy_r);
        mul_b = OW'(w);
        pa_nxt = mul_p;
        if (cx_r >= w || int'(cy_r) >= GRID_HEIGHT) begin
          state_nxt = ocr_pkg::S_PN;
        end else begin
          state_nxt = ocr_pkg::S_PR;
        end
      end
      ocr_pkg::S_PR: begin
        st_rd_en = 1'b1;
        state_nxt = ocr_pkg::S_PW;
      end
      ocr_pkg::S_PW: begin
        st_wr_en = 1'b1;
        if (csum > 16'sd127) begin
          st_wr_data[15:8] = 8'(ocr_pkg::COVER_MAX);
        end else if (csum < -16'sd127) begin
          st_wr_data[15:8] = 8'(-ocr_pkg::COVER_MAX);
        end else begin
          st_wr_data[15:8] = csum[7:0];
        end
        if (asum > 16'sd254) begin
          st_wr_data[7:0] = 8'(ocr_pkg::AREA_MAX);
        end else if (asum < 0) begin
          st_wr_data[7:0] = '0;
        end else begin
          st_wr_data[7:0] = asum[7:0];
        end
        state_nxt = ocr_pkg::S_PN;
      end
      ocr_pkg::S_PN: begin
        if (final_r) begin
          state_nxt = ocr_pkg::S_IDLE;
        end else begin
          pn_nxt = tn_r;
          pd_nxt = td_r;
          qx_nxt = ix_r;
          qy_nxt = iy_r;
          state_nxt = ocr_pkg::S_STEP;
        end
      end
      ocr_pkg::S_RBASE: begin
        mul_a = OW'(row_r);
        mul_b = OW'(w);
        pa_nxt = mul_p;
        col_nxt = '0;
        acc_nxt = '0;
        row_ok_nxt = int'(row_r) < GRID_HEIGHT;
        state_nxt = ocr_pkg::S_RRD;
      end
      ocr_pkg::S_RRD: begin
        st_rd_en = row_ok_r;
        st_rd_addr = pa_r[AW-1:0] + AW'(col_r);
        state_nxt = ocr_pkg::S_RMUL;
      end
      ocr_pkg::S_RMUL: begin
        mul_a = OW'(cabs);
        mul_b = OW'(ar);
        pb_nxt = mul_p;
        state_nxt = ocr_pkg::S_RSUM;
      end
      ocr_pkg::S_RSUM: begin
        v_nxt = cv[7] ? acc_r - AC'(q9) : acc_r + AC'(q9);
        acc_nxt = acc_r + AC'(cv);
        state_nxt = ocr_pkg::S_ROUT;
      end
      ocr_pkg::S_ROUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          if (vabs > AC'(ocr_pkg::UNIT)) begin
            out_pixel_nxt = 8'(ocr_pkg::PIX_MAX);
          end else begin
            out_pixel_nxt = 8'(ocr_pkg::div127(16'(vabs) * 16'(ocr_pkg::PIX_MAX)));
          end
          out_column_nxt = col_r[4:0];
          out_last_nxt = (col_r == w - ocr_pkg::CFG_W'(1));
          col_nxt = col_r + ocr_pkg::CFG_W'(1);
          state_nxt = (col_r == w - ocr_pkg::CFG_W'(1)) ? ocr_pkg::S_IDLE : ocr_pkg::S_RRD;
        end
      end
      default: begin
        state_nxt = ocr_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid  = out_valid_r;
  assign out_pixel  = out_pixel_r;
  assign out_column = out_column_r;
  assign out_last   = out_last_r;

endmodule
`default_nettype wire

// ===== dv/outline_coverage_rasterizer_unit_tb.sv =====
// Testbench for the outline coverage rasterizer: directed table, then random traffic.
module outline_coverage_rasterizer_unit_tb;

  localparam int GW = ocr_pkg::GRID_WIDTH_DEF;
  localparam int GH = ocr_pkg::GRID_HEIGHT_DEF;
  localparam int CELLS = GW * GH;

  typedef struct {
    ocr_pkg::func_t   func;
    logic [11:0]      bx, by, ex, ey;
    logic [4:0]       row;
    int               fixed_pix;
  } seg_item_t;

  typedef struct {
    logic [7:0] pixel;
    logic [4:0] column;
    logic       last;
  } pixel_t;

  logic clk, rst_n;
  logic cfg_we;
  logic [ocr_pkg::CFG_W-1:0] cfg_wdata;
  logic in_valid, in_stall, in_func;
  logic [11:0] in_begin_x, in_begin_y, in_end_x, in_end_y;
  logic [4:0] in_row_index;
  logic out_valid, out_stall;
  logic [7:0] out_pixel;
  logic [4:0] out_column;
  logic out_last;

  outline_coverage_rasterizer_unit i_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_begin_x(in_begin_x), .in_begin_y(in_begin_y), .in_end_x(in_end_x),
    .in_end_y(in_end_y), .in_row_index(in_row_index),
    .out_valid(out_valid), .out_stall(out_stall), .out_pixel(out_pixel),
    .out_column(out_column), .out_last(out_last)
  );

  logic signed [7:0] cov_mirror [CELLS];
  logic [7:0]        area_mirror [CELLS];
  int                width_cfg;
  pixel_t            pixel_queue[$];
  int                fail_cnt;
  int                send_idle_pct, recv_idle_pct;
  bit                hold_off;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic int eff_w();
    if (width_cfg < 1) return 1;
    if (width_cfg > GW) return GW;
    return width_cfg;
  endfunction

  function automatic void add_piece(longint bx, longint by, longint ex, longint ey);
    longint w, cx, cy, idx, c, a;
    w = eff_w();
    cx = (bx < ex ? bx : ex) / ocr_pkg::UNIT;
    cy = (by < ey ? by : ey) / ocr_pkg::UNIT;
    if (cx >= w || cy >= GH) return;
    idx = cy * w + cx;
    c = longint'(cov_mirror[idx]) +
        ((ey - cy * ocr_pkg::UNIT) - (by - cy * ocr_pkg::UNIT));
    if (c > 127) c = 127;
    if (c < -127) c = -127;
    cov_mirror[idx] = c[7:0];
    a = longint'(area_mirror[idx]) + 254 - (ex - cx * ocr_pkg::UNIT) -
        (bx - cx * ocr_pkg::UNIT);
    if (a > 254) a = 254;
    if (a < 0) a = 0;
    area_mirror[idx] = a[7:0];
  endfunction

  function automatic longint round_cross(longint b, longint d, longint n, longint q);
    longint p;
    p = b * q + n * d;
    if (p < 0) p = 0;
    return (2 * p + q) / (2 * q);
  endfunction

  function automatic void trace_segment(longint bx, longint by, longint ex, longint ey);
    longint dx, dy, nx, ny, sx, sy, pn, pd, qx, qy, tn, td, xn, xd, yn, yd, x, y;
    bit okx, oky, takex;
    dx = ex - bx; dy = ey - by;
    nx = 0; ny = 0; sx = 0; sy = 0; pn = 0; pd = 1; qx = bx; qy = by;
    if (dx > 0) begin
      nx = ((bx + ocr_pkg::UNIT - 1) / ocr_pkg::UNIT) * ocr_pkg::UNIT; sx = ocr_pkg::UNIT;
    end else if (dx < 0) begin
      nx = (bx / ocr_pkg::UNIT) * ocr_pkg::UNIT; sx = -ocr_pkg::UNIT;
    end
    if (dy > 0) begin
      ny = ((by + ocr_pkg::UNIT - 1) / ocr_pkg::UNIT) * ocr_pkg::UNIT; sy = ocr_pkg::UNIT;
    end else if (dy < 0) begin
      ny = (by / ocr_pkg::UNIT) * ocr_pkg::UNIT; sy = -ocr_pkg::UNIT;
    end
    forever begin
      okx = (dx > 0 && nx <= ex) || (dx < 0 && nx >= ex);
      oky = (dy > 0 && ny <= ey) || (dy < 0 && ny >= ey);
      if (!okx && !oky) break;
      xn = 0; xd = 1; yn = 0; yd = 1;
      if (okx) begin
        xn = dx > 0 ? nx - bx : bx - nx;
        xd = dx > 0 ? dx : -dx;
      end
      if (oky) begin
        yn = dy > 0 ? ny - by : by - ny;
        yd = dy > 0 ? dy : -dy;
      end
      takex = (okx && oky) ? (xn * yd < yn * xd) : okx;
      if (takex) begin tn = xn; td = xd; nx += sx; end
      else begin tn = yn; td = yd; ny += sy; end
      if (tn * pd == pn * td) continue;
      x = round_cross(bx, dx, tn, td);
      y = round_cross(by, dy, tn, td);
      add_piece(qx, qy, x, y);
      pn = tn; pd = td; qx = x; qy = y;
    end
    add_piece(qx, qy, ex, ey);
  endfunction

  // fixed_pix >= 0 types in every pixel of a resolve row
  function automatic void predict_item(seg_item_t it);
    longint w, acc, cv, ar, v, s;
    pixel_t p;
    if (it.func == ocr_pkg::FUNC_LINE) begin
      trace_segment(it.bx, it.by, it.ex, it.ey);
      return;
    end
    w = eff_w();
    acc = 0;
    for (int c = 0; c < w; c++) begin
      s = 0;
      if (it.row < GH) begin
        cv = cov_mirror[it.row * w + c];
        ar = area_mirror[it.row * w + c];
        v = acc + cv * ar / 254;
        s = v * 255 / ocr_pkg::UNIT;
        if (s < 0) s = -s;
        if (s > 255) s = 255;
        acc += cv;
      end
      p.pixel = (it.fixed_pix >= 0) ? 8'(it.fixed_pix) : 8'(s);
      p.column = 5'(c);
      p.last = (c == w - 1);
      pixel_queue.push_back(p);
    end
  endfunction

  always @(posedge clk) begin
    pixel_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pixel_queue.size() == 0) begin
        $error("unexpected transfer column %0d", out_column);
        fail_cnt++;
      end else begin
        e = pixel_queue.pop_front();
        if (out_pixel !== e.pixel) begin
          $error("pixel expected %0d actual %0d", e.pixel, out_pixel); fail_cnt++;
        end
        if (out_column !== e.column) begin
          $error("column expected %0d actual %0d", e.column, out_column); fail_cnt++;
        end
        if (out_last !== e.last) begin
          $error("last expected %0d actual %0d", e.last, out_last); fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
  end

  task automatic send_item(seg_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= it.func;
    in_begin_x <= it.bx; in_begin_y <= it.by;
    in_end_x <= it.ex; in_end_y <= it.ey;
    in_row_index <= it.row;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(it);
  endtask

  task automatic drain_and_idle();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pixel_queue.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (3000) @(posedge clk);
  endtask

  task automatic write_width(int w);
    cfg_we <= 1'b1;
    cfg_wdata <= ocr_pkg::CFG_W'(w);
    @(posedge clk);
    cfg_we <= 1'b0;
    width_cfg = w;
  endtask

  function automatic seg_item_t rand_item(int span);
    seg_item_t it;
    int cx, cy;
    it.fixed_pix = -1;
    it.bx = '0; it.by = '0; it.ex = '0; it.ey = '0;
    it.row = 5'($urandom_range(GH - 1));
    if ($urandom_range(9) < 2) begin
      it.func = ocr_pkg::FUNC_RESOLVE;
      if ($urandom_range(19) == 0) it.row = 5'($urandom);
    end else begin
      it.func = ocr_pkg::FUNC_LINE;
      cx = $urandom_range(span * ocr_pkg::UNIT);
      cy = $urandom_range(span * ocr_pkg::UNIT);
      it.bx = 12'(cx); it.by = 12'(cy);
      if ($urandom_range(9) == 0) begin
        it.ex = 12'($urandom_range(4064)); it.ey = 12'($urandom_range(4064));
      end else begin
        it.ex = 12'($urandom_range(span * ocr_pkg::UNIT));
        it.ey = 12'($urandom_range(span * ocr_pkg::UNIT));
      end
      if ($urandom_range(7) == 0) it.bx = 12'((cx / ocr_pkg::UNIT) * ocr_pkg::UNIT);
      if ($urandom_range(7) == 0) it.ey = 12'(($urandom_range(span)) * ocr_pkg::UNIT);
    end
    return it;
  endfunction

  seg_item_t dir_tab[] = '{
    '{ocr_pkg::FUNC_RESOLVE, 0, 0, 0, 0, 5'd0, 0},
    '{ocr_pkg::FUNC_RESOLVE, 0, 0, 0, 0, 5'd31, 0},
    '{ocr_pkg::FUNC_LINE, 12'd0, 12'd0, 12'd4064, 12'd4064, 5'd0, -1},
    '{ocr_pkg::FUNC_LINE, 12'd4064, 12'd4064, 12'd0, 12'd0, 5'd0, -1},
    '{ocr_pkg::FUNC_LINE, 12'd4095, 12'd4095, 12'd4095, 12'd0, 5'd31, -1},
    '{ocr_pkg::FUNC_LINE, 12'd127, 12'd127, 12'd254, 12'd254, 5'd0, -1},
    '{ocr_pkg::FUNC_LINE, 12'd300, 12'd300, 12'd300, 12'd300, 5'd0, -1},
    '{ocr_pkg::FUNC_LINE, 12'd10, 12'd0, 12'd10, 12'd1000, 5'd0, -1},
    '{ocr_pkg::FUNC_LINE, 12'd10, 12'd0, 12'd10, 12'd1000, 5'd0, -1},
    '{ocr_pkg::FUNC_LINE, 12'd50, 12'd100, 12'd600, 12'd381, 5'd0, -1},
    '{ocr_pkg::FUNC_LINE, 12'd600, 12'd381, 12'd50, 12'd100, 5'd0, -1},
    '{ocr_pkg::FUNC_LINE, 12'd2000, 12'd127, 12'd2000, 12'd4064, 5'd0, -1},
    '{ocr_pkg::FUNC_RESOLVE, 0, 0, 0, 0, 5'd0, -1},
    '{ocr_pkg::FUNC_RESOLVE, 0, 0, 0, 0, 5'd1, -1},
    '{ocr_pkg::FUNC_RESOLVE, 0, 0, 0, 0, 5'd2, -1},
    '{ocr_pkg::FUNC_RESOLVE, 0, 0, 0, 0, 5'd31, -1}
  };

  initial begin
    seg_item_t it;
    int widths[6] = '{1, 0, 63, 7, 32, 17};
    for (int i = 0; i < CELLS; i++) begin
      cov_mirror[i] = 0; area_mirror[i] = 0;
    end
    width_cfg = ocr_pkg::CFG_RESET;
    fail_cnt = 0;
    hold_off = 0;
    send_idle_pct = 0; recv_idle_pct = 0;
    rst_n = 0; cfg_we = 0; cfg_wdata = '0; in_valid = 0; in_func = 0;
    in_begin_x = '0; in_begin_y = '0; in_end_x = '0; in_end_y = '0; in_row_index = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_tab[i]) send_item(dir_tab[i]);
    drain_and_idle();
    for (int ph = 0; ph < 6; ph++) begin
      write_width(widths[ph]);
      send_idle_pct = (ph < 2) ? 8 : (ph < 4) ? 86 : 0;
      recv_idle_pct = (ph < 2) ? 86 : (ph < 4) ? 8 : 0;
      for (int n = 0; n < 58; n++) begin
        it = rand_item((ph == 5 && n < 10) ? 31 : 6);
        send_item(it);
        if (ph == 4 && n == 20) begin
          hold_off = 1;
          fork
            begin
              repeat (600) @(posedge clk);
              hold_off = 0;
            end
          join_none
          it.func = ocr_pkg::FUNC_RESOLVE;
          it.fixed_pix = -1;
          repeat (3) send_item(it);
        end
      end
      drain_and_idle();
    end
    if (pixel_queue.size() != 0) begin
      $error("%0d pixels never arrived", pixel_queue.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== outline_coverage_rasterizer_unit.f =====
rtl/ocr_pkg.sv
rtl/ocr_div.sv
rtl/ocr_store.sv
rtl/outline_coverage_rasterizer_unit.sv
dv/outline_coverage_rasterizer_unit_tb.sv
